FILE: design/half_step_stepper_speed_driver_assert.svh
// Assertion macros for the half-step stepper speed driver.
`ifndef HALF_STEP_STEPPER_SPEED_DRIVER_ASSERT_SVH
`define HALF_STEP_STEPPER_SPEED_DRIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HSSD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("half-step driver check failed");

// Next-cycle implication, checked outside reset.
`define HSSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("half-step driver check failed");

`endif

FILE: design/hssd_pkg.sv
package hssd_pkg;

    localparam int TICK_W     = 27;
    localparam int RELOAD_W   = 16;
    localparam int RATE_W     = 16;
    localparam int DEAD_W     = 15;
    localparam int INTERVAL_W = 24;
    localparam int COIL_W     = 4;
    localparam int NEXT_W     = 16;
    localparam int DIR_W      = 2;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELOAD       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 3'd6;

    localparam logic [TICK_W-1:0]     RST_TICK_RATE    = 27'd1680000;
    localparam logic [RELOAD_W-1:0]   RST_RELOAD       = 16'd33601;
    localparam logic [RATE_W-1:0]     RST_MIN_RATE     = 16'd2;
    localparam logic [RATE_W-1:0]     RST_MAX_RATE     = 16'd500;
    localparam logic [DEAD_W-1:0]     RST_DEAD_ZONE    = 15'd16;
    localparam logic [INTERVAL_W-1:0] RST_MIN_INTERVAL = 24'd200;
    localparam logic [INTERVAL_W-1:0] RST_MAX_INTERVAL = 24'd1000000;

    localparam logic KIND_SPEED   = 1'b0;
    localparam logic KIND_COMPARE = 1'b1;

    localparam logic [DIR_W-1:0] DIR_STOP = 2'b00;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
    localparam logic [DIR_W-1:0] DIR_REV  = 2'b11;

    typedef struct packed {
        logic load_item;
        logic mul_step;
        logic div_start;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic bypass;
        logic div_busy;
    } t_dp_sts;

    function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

FILE: design/hssd_in_if.sv
interface hssd_in_if #(
    parameter int CMD_W = 16,
    parameter int CNT_W = 16
) ();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic signed [CMD_W-1:0] speed_command;
    logic [CNT_W-1:0]        counter_value;

    modport source (output valid, output kind, output speed_command,
                    output counter_value, input ready);
    modport sink   (input valid, input kind, input speed_command,
                    input counter_value, output ready);
endinterface

FILE: design/hssd_out_if.sv
interface hssd_out_if
    import hssd_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [COIL_W-1:0]       coil_pattern;
    logic [NEXT_W-1:0]       next_compare;
    logic signed [DIR_W-1:0] direction;
    logic [INTERVAL_W-1:0]   step_interval;

    modport source (output valid, output coil_pattern, output next_compare,
                    output direction, output step_interval, input ready);
    modport sink   (input valid, input coil_pattern, input next_compare,
                    input direction, input step_interval, output ready);
endinterface

FILE: design/half_step_stepper_speed_driver.sv
// Channel   Dir  Beat fields
// i_in      in   kind, speed_command, counter_value
// o_out     out  coil_pattern, next_compare, direction, step_interval
// i_cfg_*   in   write enable, register index, data (no handshake)
//
// One item at a time. A compare beat, or a speed beat outside the dead
// zone with a positive rate, passes through the bit-serial divider shared
// by the interval and the compare modulo. A dead-zone or non-positive-rate
// speed beat skips the divider. Input is taken again while a result beat
// still waits in the output register; a stalled output holds the next
// result in the write state. Reset is synchronous and loads the register
// defaults.
`include "half_step_stepper_speed_driver_assert.svh"

module half_step_stepper_speed_driver
    import hssd_pkg::*;
#(
    parameter int COUNTER_WIDTH     = 16,
    parameter int COMMAND_FRAC_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hssd_in_if.sink               i_in,
    hssd_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    out_valid;

    hssd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hssd_dp #(
        .COUNTER_WIDTH     (COUNTER_WIDTH),
        .COMMAND_FRAC_BITS (COMMAND_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_in.kind),
        .i_speed_command (i_in.speed_command),
        .i_counter_value (i_in.counter_value),
        .o_coil_pattern  (o_out.coil_pattern),
        .o_next_compare  (o_out.next_compare),
        .o_direction     (o_out.direction),
        .o_step_interval (o_out.step_interval)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    `HSSD_ASSERT_IMPLIES(a_ready_not_dividing, i_clk, i_rst_n, in_ready, !sts.div_busy)
    `HSSD_ASSERT_IMPLIES(a_commit_slot_free, i_clk, i_rst_n, cmd.commit, (!out_valid || o_out.ready))
    `HSSD_ASSERT_IMPLIES(a_stopped_coils_off, i_clk, i_rst_n, (out_valid && (o_out.direction == DIR_STOP)), (o_out.coil_pattern == '0))
    `HSSD_ASSERT_NEXT(a_commit_shows_beat, i_clk, i_rst_n, cmd.commit, out_valid)
endmodule

FILE: design/hssd_div.sv
module hssd_div #(
    parameter int DVD_W = 41,
    parameter int DVS_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DVD_W-1:0] o_quotient,
    output logic [DVS_W-1:0] o_remainder
);
    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic             ge;
    logic [DVS_W:0]   diff;

    // One quotient bit per cycle, restoring.
    assign trial = {r_rem, r_q[DVD_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], ge};
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;
endmodule

FILE: design/hssd_dp.sv
module hssd_dp
    import hssd_pkg::*;
#(
    parameter int COUNTER_WIDTH     = 16,
    parameter int COMMAND_FRAC_BITS = 14
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  t_dp_cmd                            i_cmd,
    output t_dp_sts                            o_sts,
    input  logic                               i_cfg_we,
    input  logic [CFG_IDX_W-1:0]               i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]              i_cfg_data,
    input  logic                               i_kind,
    input  logic signed [COMMAND_FRAC_BITS+1:0] i_speed_command,
    input  logic [COUNTER_WIDTH-1:0]           i_counter_value,
    output logic [COIL_W-1:0]                  o_coil_pattern,
    output logic [NEXT_W-1:0]                  o_next_compare,
    output logic signed [DIR_W-1:0]            o_direction,
    output logic [INTERVAL_W-1:0]              o_step_interval
);
    localparam int F      = COMMAND_FRAC_BITS;
    localparam int CMD_W  = F + 2;
    localparam int CW     = COUNTER_WIDTH;
    localparam int MAG_CW = (CMD_W > DEAD_W) ? CMD_W : DEAD_W;
    localparam int PROD_W = RATE_W + 1 + CMD_W + 1;
    localparam int DVS_W  = F + 18;
    localparam int MOD_W  = RELOAD_W + 1;
    localparam int SUM_W  = ((CW > INTERVAL_W) ? CW : INTERVAL_W) + 1;
    localparam int TDV_W  = TICK_W + F;
    localparam int DVD_W  = (TDV_W > SUM_W) ? TDV_W : SUM_W;

    // configuration
    logic [TICK_W-1:0]     r_tick_rate;
    logic [RELOAD_W-1:0]   r_reload;
    logic [RATE_W-1:0]     r_min_rate;
    logic [RATE_W-1:0]     r_max_rate;
    logic [DEAD_W-1:0]     r_dead_zone;
    logic [INTERVAL_W-1:0] r_min_int;
    logic [INTERVAL_W-1:0] r_max_int;

    // motor state
    logic [PHASE_W-1:0]    r_phase;
    logic [DIR_W-1:0]      r_dir;
    logic [INTERVAL_W-1:0] r_interval;
    logic [COIL_W-1:0]     r_coil;

    // item and intermediates
    logic                     r_kind;
    logic signed [CMD_W-1:0]  r_cmd;
    logic [CW-1:0]            r_cnt;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_dead;

    // result
    logic [COIL_W-1:0]     r_out_coil;
    logic [NEXT_W-1:0]     r_out_next;
    logic [DIR_W-1:0]      r_out_dir;
    logic [INTERVAL_W-1:0] r_out_interval;

    logic [CMD_W-1:0]         mag;
    logic                     neg;
    logic                     dead_c;
    logic signed [RATE_W:0]   diff;
    logic signed [CMD_W:0]    mag_s;
    logic signed [PROD_W-1:0] prod_c;
    logic [PROD_W-1:0]        min_sh;
    logic signed [PROD_W-1:0] rate_c;
    logic                     rate_pos;
    logic [MOD_W-1:0]         modulus;
    logic [INTERVAL_W-1:0]    step;
    logic [SUM_W-1:0]         sum;
    logic [DVD_W-1:0]         div_dvd;
    logic [DVS_W-1:0]         div_dvs;
    logic                     div_busy;
    logic [DVD_W-1:0]         quot;
    logic [DVS_W-1:0]         rem;
    logic [DVD_W-1:0]         q_lo;
    logic [INTERVAL_W-1:0]    q_cl;

    logic [PHASE_W-1:0]    n_phase;
    logic [DIR_W-1:0]      n_dir;
    logic [INTERVAL_W-1:0] n_interval;
    logic [COIL_W-1:0]     n_coil;
    logic [NEXT_W-1:0]     n_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= RST_TICK_RATE;
            r_reload    <= RST_RELOAD;
            r_min_rate  <= RST_MIN_RATE;
            r_max_rate  <= RST_MAX_RATE;
            r_dead_zone <= RST_DEAD_ZONE;
            r_min_int   <= RST_MIN_INTERVAL;
            r_max_int   <= RST_MAX_INTERVAL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TICK_RATE:    r_tick_rate <= i_cfg_data[TICK_W-1:0];
                CFG_RELOAD:       r_reload    <= i_cfg_data[RELOAD_W-1:0];
                CFG_MIN_RATE:     r_min_rate  <= i_cfg_data[RATE_W-1:0];
                CFG_MAX_RATE:     r_max_rate  <= i_cfg_data[RATE_W-1:0];
                CFG_DEAD_ZONE:    r_dead_zone <= i_cfg_data[DEAD_W-1:0];
                CFG_MIN_INTERVAL: r_min_int   <= i_cfg_data[INTERVAL_W-1:0];
                CFG_MAX_INTERVAL: r_max_int   <= i_cfg_data[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // Magnitude; the most negative command maps to 2^(CMD_W-1).
    assign neg    = r_cmd[CMD_W-1];
    assign mag    = neg ? ($unsigned(~r_cmd) + CMD_W'(1)) : $unsigned(r_cmd);
    assign dead_c = MAG_CW'(mag) <= MAG_CW'(r_dead_zone);
    assign diff   = $signed({1'b0, r_max_rate}) - $signed({1'b0, r_min_rate});
    assign mag_s  = $signed({1'b0, mag});
    assign prod_c = diff * mag_s;

    assign min_sh   = PROD_W'({r_min_rate, {F{1'b0}}});
    assign rate_c   = r_prod + $signed(min_sh);
    assign rate_pos = !rate_c[PROD_W-1] && (rate_c != '0);

    assign modulus = {1'b0, r_reload} + MOD_W'(1);
    assign step    = (r_interval != '0) ? r_interval : INTERVAL_W'(modulus[MOD_W-1:1]);
    assign sum     = SUM_W'(r_cnt) + SUM_W'(step);

    always_comb begin
        if (r_kind == KIND_SPEED) begin
            div_dvd = DVD_W'({r_tick_rate, {F{1'b0}}});
            div_dvs = rate_c[DVS_W-1:0];
        end else begin
            div_dvd = DVD_W'(sum);
            div_dvs = DVS_W'(modulus);
        end
    end

    hssd_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_dvd),
        .i_divisor   (div_dvs),
        .o_busy      (div_busy),
        .o_quotient  (quot),
        .o_remainder (rem)
    );

    // Lower limit first, upper limit last.
    assign q_lo = (quot < DVD_W'(r_min_int)) ? DVD_W'(r_min_int) : quot;
    assign q_cl = (q_lo > DVD_W'(r_max_int)) ? r_max_int : q_lo[INTERVAL_W-1:0];

    always_comb begin
        n_phase    = r_phase;
        n_dir      = r_dir;
        n_interval = r_interval;
        n_coil     = r_coil;
        n_next     = '0;
        if (r_kind == KIND_SPEED) begin
            if (r_dead) begin
                n_dir  = DIR_STOP;
                n_coil = '0;
            end else begin
                n_dir      = neg ? DIR_REV : DIR_FWD;
                n_interval = rate_pos ? q_cl : r_max_int;
            end
        end else begin
            n_next = rem[NEXT_W-1:0];
            if (r_dir != DIR_STOP) begin
                n_phase = r_phase + {r_dir[DIR_W-1], r_dir};
                n_coil  = coil_of(n_phase);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_dir      <= DIR_STOP;
            r_interval <= '0;
            r_coil     <= '0;
        end else if (i_cmd.commit) begin
            r_phase    <= n_phase;
            r_dir      <= n_dir;
            r_interval <= n_interval;
            r_coil     <= n_coil;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind <= i_kind;
            r_cmd  <= i_speed_command;
            r_cnt  <= i_counter_value;
        end
        if (i_cmd.mul_step) begin
            r_prod <= prod_c;
            r_dead <= dead_c;
        end
        if (i_cmd.commit) begin
            r_out_coil     <= n_coil;
            r_out_next     <= n_next;
            r_out_dir      <= n_dir;
            r_out_interval <= n_interval;
        end
    end

    assign o_sts.bypass   = (r_kind == KIND_SPEED) && (r_dead || !rate_pos);
    assign o_sts.div_busy = div_busy;

    assign o_coil_pattern  = r_out_coil;
    assign o_next_compare  = r_out_next;
    assign o_direction     = $signed(r_out_dir);
    assign o_step_interval = r_out_interval;
endmodule

FILE: design/hssd_ctrl.sv
module hssd_ctrl
    import hssd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_WRITE
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load_item = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_step  = (r_state == S_MUL);
        o_cmd.div_start = (r_state == S_LOAD) && !i_sts.bypass;
        o_cmd.commit    = (r_state == S_WRITE) && slot_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= i_sts.bypass ? S_WRITE : S_DIV;
                end
                S_DIV: begin
                    if (!i_sts.div_busy) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    // hold until the previous beat has left
                    if (slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule
